// ===== rtl/kernel_instance_pool_allocator_macros.svh =====
`ifndef KERNEL_INSTANCE_POOL_ALLOCATOR_MACROS_SVH
`define KERNEL_INSTANCE_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define KIPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kipa assertion failed");

// next-cycle implication
`define KIPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kipa assertion failed");

`endif

// ===== rtl/kipa_pkg.sv =====
`default_nettype none
package kipa_pkg;

  localparam int FUNC_W     = 2;
  localparam int KID_W      = 32;
  localparam int SLOT_IDX_W = 7;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 8;

  localparam logic [FUNC_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [FUNC_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_COUNT   = 2'd2;
  localparam logic [FUNC_W-1:0] OP_LOAD    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_IDLE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_RELEASE = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic empty;
    logic hit;
    logic busy;
  } kipa_cmp_t;

endpackage
`default_nettype wire

// ===== rtl/kipa_ram.sv =====
`default_nettype none
module kipa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/kipa_cmp.sv =====
`default_nettype none
module kipa_cmp #(
  parameter int ID_BITS = 32
) (
  input  wire logic [ID_BITS:0]   entry,
  input  wire logic               entry_vld,
  input  wire logic [ID_BITS-1:0] key,
  output kipa_pkg::kipa_cmp_t     res
);
  import kipa_pkg::*;

  logic [ID_BITS-1:0] id;

  // never-written slots read as empty and idle
  assign id        = entry_vld ? entry[ID_BITS-1:0] : '0;
  assign res.empty = (id == '0);
  assign res.hit   = (id != '0) && (id == key);
  assign res.busy  = entry_vld && entry[ID_BITS];

endmodule
`default_nettype wire

// ===== rtl/kernel_instance_pool_allocator.sv =====
`default_nettype none
// Kernel instance slot pool with first-fit acquire. One item is taken at a time; in_stall stays
// high from acceptance until the result is registered. Acquire and count walk the slot table
// one slot per cycle through the single read port of the table memory; acquire stops early at a
// matching idle slot or at an empty slot; release and load each touch only their own slot. The
// result sits in an output register, and a new item is accepted while it waits.
// Slot ids and busy flags share one memory word; a per-slot valid flop cleared by reset marks
// never-written slots as empty, so no clearing pass is needed after reset.
module kernel_instance_pool_allocator #(
  parameter int SLOT_COUNT = 128,
  parameter int ID_BITS    = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [kipa_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [kipa_pkg::KID_W-1:0]      in_kernel_id,
  input  wire logic [kipa_pkg::SLOT_IDX_W-1:0] in_slot_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [kipa_pkg::STATUS_W-1:0]        out_status,
  output logic [kipa_pkg::SLOT_IDX_W-1:0]      out_granted_slot,
  output logic [kipa_pkg::COUNT_W-1:0]         out_instance_count
);
  import kipa_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_REL, S_PUSH} state_t;

  state_t                state_r, state_nxt;
  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [ID_BITS-1:0]    key_r, key_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  rng_r, rng_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [SLOT_IDX_W-1:0] granted_r, granted_nxt;
  logic [SLOT_COUNT-1:0] vld_r, vld_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [SLOT_IDX_W-1:0] out_granted_slot_r, out_granted_slot_nxt;
  logic [COUNT_W-1:0]    out_instance_count_r, out_instance_count_nxt;

  logic                  in_acc;
  logic                  in_range;
  logic [IDX_W-1:0]      in_idx;
  logic                  last;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [ID_BITS:0]      wdata;
  logic [IDX_W-1:0]      rd_addr;
  logic [ID_BITS:0]      rd_data;
  kipa_cmp_t             cmp;

  kipa_ram #(
    .WIDTH (ID_BITS + 1),
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  kipa_cmp #(
    .ID_BITS (ID_BITS)
  ) u_cmp (
    .entry     (rd_data),
    .entry_vld (rd_vld_r),
    .key       (key_r),
    .res       (cmp)
  );

  assign in_stall           = (state_r != S_IDLE);
  assign in_acc             = in_valid && !in_stall;
  assign in_range           = (32'(in_slot_index) < SLOT_COUNT);
  assign in_idx             = IDX_W'(in_slot_index);
  assign last               = (idx_r == LAST_IDX);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_slot   = out_granted_slot_r;
  assign out_instance_count = out_instance_count_r;

  always_comb begin
    state_nxt              = state_r;
    func_nxt               = func_r;
    key_nxt                = key_r;
    idx_nxt                = idx_r;
    rng_nxt                = rng_r;
    cnt_nxt                = cnt_r;
    status_nxt             = status_r;
    granted_nxt            = granted_r;
    vld_nxt                = vld_r;
    out_valid_nxt          = out_valid_r && out_stall;
    out_status_nxt         = out_status_r;
    out_granted_slot_nxt   = out_granted_slot_r;
    out_instance_count_nxt = out_instance_count_r;
    we                     = 1'b0;
    waddr                  = idx_r;
    wdata                  = '0;
    rd_addr                = IDX_W'(idx_r + 1'b1);

    unique case (state_r)
      S_IDLE: begin
        rd_addr = (in_func == OP_RELEASE) ? in_idx : '0;
        if (in_acc) begin
          func_nxt    = in_func;
          key_nxt     = in_kernel_id[ID_BITS-1:0];
          idx_nxt     = (in_func == OP_RELEASE) ? in_idx : '0;
          rng_nxt     = in_range;
          cnt_nxt     = '0;
          status_nxt  = ST_OK;
          granted_nxt = '0;
          unique case (in_func)
            OP_LOAD: begin
              if (in_range) begin
                we             = 1'b1;
                waddr          = in_idx;
                wdata          = {1'b0, in_kernel_id[ID_BITS-1:0]};
                vld_nxt[in_idx] = 1'b1;
              end
              state_nxt = S_PUSH;
            end
            OP_RELEASE: state_nxt = S_REL;
            default:    state_nxt = S_SCAN;
          endcase
        end
      end
      S_REL: begin
        if (rng_r && !cmp.empty) begin
          we         = 1'b1;
          wdata      = {1'b0, rd_data[ID_BITS-1:0]};
          status_nxt = ST_OK;
        end else begin
          status_nxt = ST_EMPTY_RELEASE;
        end
        state_nxt = S_PUSH;
      end
      S_SCAN: begin
        if (func_r == OP_ACQUIRE) begin
          priority if (cmp.empty) begin
            status_nxt = ST_NONE_IDLE;
            state_nxt  = S_PUSH;
          end else if (cmp.hit && !cmp.busy) begin
            we          = 1'b1;
            wdata       = {1'b1, key_r};
            status_nxt  = ST_OK;
            granted_nxt = SLOT_IDX_W'(idx_r);
            state_nxt   = S_PUSH;
          end else if (last) begin
            status_nxt = ST_NONE_IDLE;
            state_nxt  = S_PUSH;
          end else begin
            idx_nxt = IDX_W'(idx_r + 1'b1);
          end
        end else begin
          if (cmp.hit && (cnt_r != COUNT_MAX)) begin
            cnt_nxt = cnt_r + 8'd1;
          end
          if (last) begin
            state_nxt = S_PUSH;
          end else begin
            idx_nxt = IDX_W'(idx_r + 1'b1);
          end
        end
      end
      S_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_status_nxt         = status_r;
          out_granted_slot_nxt   = granted_r;
          out_instance_count_nxt = cnt_r;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    rd_vld_nxt = (32'(rd_addr) < SLOT_COUNT) ? vld_r[rd_addr] : 1'b0;
  end

  always_ff @(posedge clk) begin
    func_r               <= func_nxt;
    key_r                <= key_nxt;
    idx_r                <= idx_nxt;
    rng_r                <= rng_nxt;
    cnt_r                <= cnt_nxt;
    status_r             <= status_nxt;
    granted_r            <= granted_nxt;
    rd_vld_r             <= rd_vld_nxt;
    out_status_r         <= out_status_nxt;
    out_granted_slot_r   <= out_granted_slot_nxt;
    out_instance_count_r <= out_instance_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kipa_checker.sv =====
`default_nettype none
`include "kernel_instance_pool_allocator_macros.svh"
module kipa_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [kipa_pkg::STATUS_W-1:0]   out_status,
  input wire logic [kipa_pkg::SLOT_IDX_W-1:0] out_granted_slot,
  input wire logic [kipa_pkg::COUNT_W-1:0]    out_instance_count
);
  import kipa_pkg::*;

  `KIPA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `KIPA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `KIPA_ASSERT_IMP(a_status_code, clk, rst_n, out_valid,
    out_status == ST_OK || out_status == ST_NONE_IDLE || out_status == ST_EMPTY_RELEASE)
  `KIPA_ASSERT_IMP(a_grant_clean, clk, rst_n, out_valid && (out_granted_slot != '0),
    (out_status == ST_OK) && (out_instance_count == '0))

endmodule

bind kernel_instance_pool_allocator kipa_checker u_kipa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_granted_slot   (out_granted_slot),
  .out_instance_count (out_instance_count)
);
`default_nettype wire
